// File: hdl/bba_pkg.sv
// Shared types, codes and a helper function for the bitmap block allocator.
package bba_pkg;

	// The usage map is held as words of this many bits.
	localparam int WORD_BITS = 32;
	localparam int WORD_SEL  = $clog2(WORD_BITS);

	// Request codes.
	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_FREE   = 2'd1;
	localparam logic [1:0] OP_FORMAT = 2'd2;

	// Response codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOT_USED = 2'd2;

	typedef enum logic [4:0] {
		S_CLEAR    = 5'b00001,
		S_IDLE     = 5'b00010,
		S_SCAN     = 5'b00100,
		S_FREE_CHK = 5'b01000,
		S_DONE     = 5'b10000
	} bba_state_t;

	// Position of the lowest clear bit of a map word.
	function automatic logic [WORD_SEL-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
		logic [WORD_SEL-1:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				r = WORD_SEL'(i);
			end
		end
		return r;
	endfunction

endpackage

// File: hdl/bba_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/bitmap_block_allocator_unit.sv
// Top level of the first-fit bitmap block allocator.
//
// Usage: one request word enters on operation/block_index with in_valid and
// in_ready; one response word leaves on status/granted_block/used_count with
// out_valid and out_ready. Every request gives exactly one response.
// The usage map lives in a RAM of 32-bit words (BLOCKS/32 words, rounded up).
// Allocation scans that RAM one word per cycle through a single compare and
// priority-encode unit, stopping at the first word that holds a free block.
// A free request reads its word, tests and writes it back, then responds. A
// format request rewrites every word, one per cycle. Allocation on a full map
// answers without a scan, because the used-block count tells at once that no
// bit is clear.
// The block takes one request at a time: in_ready is high only while it is
// idle. The response sits in an output register, so a new request is taken
// while an earlier response still waits; if the receiver stalls for longer,
// the block holds its next finished response until the register frees up.
// After reset the block runs the same clearing pass as format, with in_ready
// low, leaving block zero used and a count of one.
module bitmap_block_allocator_unit
	import bba_pkg::*;
#(
	parameter int BLOCKS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [9:0]  block_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [9:0]  granted_block,
	output logic [10:0] used_count
);

	localparam int WORDS     = (BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CW        = $clog2(BLOCKS + 1);
	localparam int LAST_BITS = BLOCKS - (WORDS - 1) * WORD_BITS;
	localparam logic [AW-1:0] LAST_WORD  = AW'(WORDS - 1);
	localparam logic [AW-1:0] FIRST_NEXT = (WORDS > 1) ? AW'(1) : AW'(0);

	bba_state_t state_q;

	logic [AW-1:0]        clr_ptr_q;
	logic                 clr_resp_q;
	logic [AW-1:0]        rd_ptr_q;
	logic [AW-1:0]        ev_ptr_s1;
	logic [AW-1:0]        idx_word_q;
	logic [WORD_SEL-1:0]  idx_bit_q;
	logic [CW-1:0]        count_q;
	logic [1:0]           res_status_q;
	logic [9:0]           res_block_q;

	logic [1:0]           out_status_q;
	logic [9:0]           out_block_q;
	logic [10:0]          out_count_q;
	logic                 out_valid_q;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	logic [31:0]          idx_ext;
	logic [AW-1:0]        idx_word;
	logic                 in_range;
	logic [WORD_BITS-1:0] pad;
	logic [WORD_BITS-1:0] scan_word;
	logic                 scan_hit;
	logic [WORD_SEL-1:0]  scan_bit;
	logic [31:0]          grant_ext;
	logic [31:0]          count_ext;
	logic                 map_full;
	logic                 accept;
	logic                 out_load;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Word and bit of the block named by a free request.
	assign idx_ext  = 32'(block_index);
	assign idx_word = idx_ext[WORD_SEL +: AW];
	assign in_range = idx_ext < 32'(BLOCKS);
	assign map_full = (count_q == CW'(BLOCKS));

	// Bits past the last block in the last word count as used, so the scan
	// never hands them out.
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			pad[b] = (ev_ptr_s1 == LAST_WORD) && (b >= LAST_BITS);
		end
	end

	// The shared scan unit: one map word is tested per cycle.
	assign scan_word = ram_rdata | pad;
	assign scan_hit  = ~&scan_word;
	assign scan_bit  = lowest_zero(scan_word);
	assign grant_ext = 32'({ev_ptr_s1, scan_bit});
	assign count_ext = 32'(count_q);

	// Map RAM port control.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ev_ptr_s1;
		ram_wdata = ram_rdata | (WORD_BITS'(1) << scan_bit);
		ram_raddr = (operation == OP_FREE) ? idx_word : AW'(0);
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_ptr_q;
				ram_wdata = (clr_ptr_q == AW'(0)) ? WORD_BITS'(1) : '0;
			end
			S_SCAN: begin
				ram_we    = scan_hit;
				ram_raddr = rd_ptr_q;
			end
			S_FREE_CHK: begin
				ram_we    = ram_rdata[idx_bit_q];
				ram_waddr = idx_word_q;
				ram_wdata = ram_rdata & ~(WORD_BITS'(1) << idx_bit_q);
			end
			default: begin
			end
		endcase
	end

	bba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(WORDS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Request sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_ptr_q  <= '0;
			clr_resp_q <= 1'b0;
			count_q    <= CW'(1);
			rd_ptr_q   <= '0;
			ev_ptr_s1  <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (clr_ptr_q == LAST_WORD) begin
						count_q <= CW'(1);
						state_q <= clr_resp_q ? S_DONE : S_IDLE;
					end else begin
						clr_ptr_q <= clr_ptr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (operation)
							OP_ALLOC: begin
								if (map_full) begin
									state_q <= S_DONE;
								end else begin
									rd_ptr_q  <= FIRST_NEXT;
									ev_ptr_s1 <= '0;
									state_q   <= S_SCAN;
								end
							end
							OP_FREE: begin
								state_q <= in_range ? S_FREE_CHK : S_DONE;
							end
							OP_FORMAT: begin
								clr_ptr_q  <= '0;
								clr_resp_q <= 1'b1;
								state_q    <= S_CLEAR;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						count_q <= count_q + CW'(1);
						state_q <= S_DONE;
					end else begin
						ev_ptr_s1 <= rd_ptr_q;
						rd_ptr_q  <= (rd_ptr_q == LAST_WORD) ? rd_ptr_q : rd_ptr_q + AW'(1);
					end
				end
				S_FREE_CHK: begin
					if (ram_rdata[idx_bit_q] && (count_q != '0)) begin
						count_q <= count_q - CW'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						clr_resp_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Response fields, settled before the block reaches its response step.
	always_ff @(posedge clk) begin
		case (state_q)
			S_CLEAR: begin
				res_status_q <= ST_OK;
				res_block_q  <= '0;
			end
			S_IDLE: begin
				idx_word_q   <= idx_word;
				idx_bit_q    <= idx_ext[WORD_SEL-1:0];
				res_block_q  <= '0;
				res_status_q <= ST_OK;
				if (operation == OP_ALLOC && map_full) begin
					res_status_q <= ST_FULL;
				end else if (operation == OP_FREE && !in_range) begin
					res_status_q <= ST_NOT_USED;
				end
			end
			S_SCAN: begin
				res_block_q <= grant_ext[9:0];
			end
			S_FREE_CHK: begin
				res_status_q <= ram_rdata[idx_bit_q] ? ST_OK : ST_NOT_USED;
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_block_q  <= res_block_q;
			out_count_q  <= count_ext[10:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign granted_block = out_block_q;
	assign used_count    = out_count_q;

endmodule

// File: hdl/bba_checker.sv
// Port-level assertions for the bitmap block allocator, bound to the top level.
module bba_checker
	import bba_pkg::*;
#(
	parameter int BLOCKS = 1024
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [9:0]  granted_block,
	input logic [10:0] used_count
);

	localparam logic [10:0] FULL_COUNT = 11'(BLOCKS);

	// A stalled response word holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(granted_block) && $stable(used_count))
		else $error("response changed while stalled");

	// The block never takes requests back to back.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken back to back");

	// Only a successful allocation names a block.
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> granted_block == '0)
		else $error("block named on failed request");

	// A full report comes only when every block is counted as used.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> used_count == FULL_COUNT)
		else $error("full reported with blocks free");

	// Status codes stay within the defined set.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_OK || status == ST_FULL || status == ST_NOT_USED)
		else $error("undefined status code");

endmodule

bind bitmap_block_allocator_unit bba_checker #(.BLOCKS(BLOCKS)) u_bba_checker (.*);
